// ----- rtl/aabb_move_clearance_check_core_macros.svh -----
// Assertion macros for the AABB move clearance check core.
// Included by the top level; needs nothing else.
`ifndef AABB_MOVE_CLEARANCE_CHECK_CORE_MACROS_SVH
`define AABB_MOVE_CLEARANCE_CHECK_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AMCC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("amcc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define AMCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("amcc assertion failed");

`endif

// ----- rtl/amcc_pkg.sv -----
// Shared types and codes for the AABB move clearance check core.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package amcc_pkg;

    typedef logic [1:0] kind_t;

    localparam kind_t KIND_OBSTACLE = 2'd0;
    localparam kind_t KIND_ENEMY    = 2'd1;
    localparam kind_t KIND_PLAYER   = 2'd2;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam int CFG_INDEX_BITS = 2;
    localparam int WINDOW_BITS    = 16;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_WINDOW_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WINDOW_HEIGHT = 2'd1;

    typedef struct packed {
        logic is_player;
        logic has_self;
    } qflags_t;

endpackage

`default_nettype wire

// ----- rtl/aabb_move_clearance_check_core.sv -----
// Top level of the AABB move clearance check: control, window registers and query state.
// Depends on amcc_pkg, amcc_table, amcc_overlap and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none

// After reset the block clears the entry table slot by slot and holds busy high meanwhile.
// A write beat is taken while idle and leaves busy low. A query beat keeps busy high through
// the window check and then a scan of the whole table, one table slot per cycle through
// the single read port of the entry memory; a query that leaves the window finishes after the
// check alone. The result appears with done high for exactly one cycle and must be taken then,
// as the block cannot be stalled; busy is already low in that cycle.
module aabb_move_clearance_check_core #(
    parameter int TABLE_SLOTS = 32,
    parameter int COORD_BITS  = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   start,
    output logic                                        busy,
    input  wire logic                                   op,
    input  wire logic [4:0]                             index,
    input  wire logic                                   entry_valid,
    input  wire amcc_pkg::kind_t                        entry_kind,
    input  wire logic signed [COORD_BITS-1:0]           pos_x,
    input  wire logic signed [COORD_BITS-1:0]           pos_y,
    input  wire logic        [COORD_BITS-2:0]           box_width,
    input  wire logic        [COORD_BITS-2:0]           box_height,
    input  wire logic                                   is_player,
    input  wire logic                                   has_self,
    input  wire logic signed [COORD_BITS-1:0]           self_x,
    input  wire logic signed [COORD_BITS-1:0]           self_y,
    output logic                                        done,
    output logic                                        allowed,
    output logic                                        out_of_bounds,
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [amcc_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  wire logic [amcc_pkg::WINDOW_BITS-1:0]       cfg_data
);

    import amcc_pkg::*;

    localparam int ADDR_BITS = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int WORD_BITS = 4 * COORD_BITS + 1;
    localparam int CMP_BITS  = ((COORD_BITS + 1) > (WINDOW_BITS + 1)) ?
                               (COORD_BITS + 2) : (WINDOW_BITS + 2);
    localparam logic [ADDR_BITS-1:0] LAST_SLOT = ADDR_BITS'(TABLE_SLOTS - 1);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_SCAN
    } state_t;

    state_t                  state_reg;
    logic [ADDR_BITS-1:0]    cnt_reg;
    logic                    hit_reg;
    logic                    done_reg;
    logic                    allowed_reg;
    logic                    oob_reg;
    logic [WINDOW_BITS-1:0]  win_w_reg;
    logic [WINDOW_BITS-1:0]  win_h_reg;

    qflags_t                        q_flags_reg;
    logic signed [COORD_BITS-1:0]   q_x_reg;
    logic signed [COORD_BITS-1:0]   q_y_reg;
    logic signed [COORD_BITS:0]     q_right_reg;
    logic signed [COORD_BITS:0]     q_bottom_reg;
    logic signed [COORD_BITS-1:0]   self_x_reg;
    logic signed [COORD_BITS-1:0]   self_y_reg;

    logic                    accept;
    logic                    wr_item;
    logic                    idx_in_range;
    logic [31:0]             idx_ext;
    logic                    mem_we;
    logic [ADDR_BITS-1:0]    mem_waddr;
    logic [WORD_BITS-1:0]    mem_wdata;
    logic [ADDR_BITS-1:0]    mem_raddr;
    logic [WORD_BITS-1:0]    mem_rdata;
    logic signed [COORD_BITS:0] right_next;
    logic signed [COORD_BITS:0] bottom_next;
    logic signed [CMP_BITS-1:0] right_cmp;
    logic signed [CMP_BITS-1:0] bottom_cmp;
    logic signed [CMP_BITS-1:0] win_w_cmp;
    logic signed [CMP_BITS-1:0] win_h_cmp;
    logic                    oob_now;

    logic                           rd_valid;
    kind_t                          rd_kind;
    logic signed [COORD_BITS-1:0]   rd_x;
    logic signed [COORD_BITS-1:0]   rd_y;
    logic        [COORD_BITS-2:0]   rd_w;
    logic        [COORD_BITS-2:0]   rd_h;
    logic                           blocked;

    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;

    assign idx_ext      = 32'(index);
    assign idx_in_range = (idx_ext < 32'(TABLE_SLOTS));
    assign wr_item      = accept && (op == OP_WRITE) && idx_in_range;

    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = cnt_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = wr_item;
            mem_waddr = idx_ext[ADDR_BITS-1:0];
            mem_wdata = {entry_valid, entry_kind, pos_x, pos_y, box_width, box_height};
        end
    end

    assign mem_raddr = (state_reg == ST_SCAN) ? (cnt_reg + 1'b1) : '0;

    amcc_table #(
        .DEPTH     (TABLE_SLOTS),
        .ADDR_BITS (ADDR_BITS),
        .DATA_BITS (WORD_BITS)
    ) u_table (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign {rd_valid, rd_kind, rd_x, rd_y, rd_w, rd_h} = mem_rdata;

    amcc_overlap #(
        .COORD_BITS (COORD_BITS)
    ) u_overlap (
        .q_flags_valid (state_reg == ST_SCAN),
        .q_flags       (q_flags_reg),
        .q_x           (q_x_reg),
        .q_y           (q_y_reg),
        .q_right       (q_right_reg),
        .q_bottom      (q_bottom_reg),
        .self_x        (self_x_reg),
        .self_y        (self_y_reg),
        .e_valid       (rd_valid),
        .e_kind        (rd_kind),
        .e_x           (rd_x),
        .e_y           (rd_y),
        .e_w           (rd_w),
        .e_h           (rd_h),
        .blocked       (blocked)
    );

    assign right_next  = (COORD_BITS+1)'(pos_x) + signed'((COORD_BITS+1)'(box_width));
    assign bottom_next = (COORD_BITS+1)'(pos_y) + signed'((COORD_BITS+1)'(box_height));

    assign right_cmp  = CMP_BITS'(q_right_reg);
    assign bottom_cmp = CMP_BITS'(q_bottom_reg);
    assign win_w_cmp  = signed'(CMP_BITS'(win_w_reg));
    assign win_h_cmp  = signed'(CMP_BITS'(win_h_reg));
    assign oob_now    = q_x_reg[COORD_BITS-1] || q_y_reg[COORD_BITS-1] ||
                        (right_cmp > win_w_cmp) || (bottom_cmp > win_h_cmp);

    always_ff @(posedge clk)
    begin
        if (accept && (op == OP_QUERY))
        begin
            q_flags_reg  <= '{is_player: is_player, has_self: has_self};
            q_x_reg      <= pos_x;
            q_y_reg      <= pos_y;
            q_right_reg  <= right_next;
            q_bottom_reg <= bottom_next;
            self_x_reg   <= self_x;
            self_y_reg   <= self_y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_w_reg <= '1;
            win_h_reg <= '1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_WINDOW_WIDTH:  win_w_reg <= cfg_data;
                CFG_WINDOW_HEIGHT: win_h_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            cnt_reg     <= '0;
            hit_reg     <= 1'b0;
            done_reg    <= 1'b0;
            allowed_reg <= 1'b0;
            oob_reg     <= 1'b0;
        end
        else
        begin
            done_reg <= ((state_reg == ST_CHECK) && oob_now) ||
                        ((state_reg == ST_SCAN) && (cnt_reg == LAST_SLOT));
            unique case (state_reg)
                ST_CLEAR:
                begin
                    if (cnt_reg == LAST_SLOT)
                    begin
                        state_reg <= ST_IDLE;
                        cnt_reg   <= '0;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_IDLE:
                begin
                    if (accept && (op == OP_QUERY))
                    begin
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK:
                begin
                    cnt_reg <= '0;
                    hit_reg <= 1'b0;
                    if (oob_now)
                    begin
                        state_reg   <= ST_IDLE;
                        allowed_reg <= 1'b0;
                        oob_reg     <= 1'b1;
                    end
                    else
                    begin
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (cnt_reg == LAST_SLOT)
                    begin
                        state_reg   <= ST_IDLE;
                        cnt_reg     <= '0;
                        allowed_reg <= !(hit_reg || blocked);
                        oob_reg     <= 1'b0;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                        hit_reg <= hit_reg || blocked;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign done          = done_reg;
    assign allowed       = allowed_reg;
    assign out_of_bounds = oob_reg;

`include "aabb_move_clearance_check_core_macros.svh"

    `AMCC_ASSERT_SAME(a_result_consistent, clk, rst_n, done_reg, !(allowed_reg && oob_reg))
    `AMCC_ASSERT_NEXT(a_no_double_result, clk, rst_n, done_reg, !done_reg)
    `AMCC_ASSERT_NEXT(a_query_goes_busy, clk, rst_n, accept && (op == OP_QUERY), busy)
    `AMCC_ASSERT_SAME(a_no_write_in_scan, clk, rst_n, state_reg == ST_SCAN, !mem_we)

endmodule

`default_nettype wire

// ----- rtl/amcc_table.sv -----
// Entry table of the clearance check: one write port, one registered read port.
// Depends on nothing beyond its parameters.
`timescale 1ns / 1ps
`default_nettype none

module amcc_table #(
    parameter int DEPTH     = 32,
    parameter int ADDR_BITS = 5,
    parameter int DATA_BITS = 65
) (
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [ADDR_BITS-1:0] waddr,
    input  wire logic [DATA_BITS-1:0] wdata,
    input  wire logic [ADDR_BITS-1:0] raddr,
    output logic      [DATA_BITS-1:0] rdata
);

    logic [DATA_BITS-1:0] mem [DEPTH];
    logic [DATA_BITS-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/amcc_overlap.sv -----
// Decides whether one stored entry blocks the query rectangle.
// Depends on amcc_pkg for the entry kinds and the query flags.
`timescale 1ns / 1ps
`default_nettype none

module amcc_overlap #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                         q_flags_valid,
    input  wire amcc_pkg::qflags_t            q_flags,
    input  wire logic signed [COORD_BITS-1:0] q_x,
    input  wire logic signed [COORD_BITS-1:0] q_y,
    input  wire logic signed [COORD_BITS:0]   q_right,
    input  wire logic signed [COORD_BITS:0]   q_bottom,
    input  wire logic signed [COORD_BITS-1:0] self_x,
    input  wire logic signed [COORD_BITS-1:0] self_y,
    input  wire logic                         e_valid,
    input  wire amcc_pkg::kind_t              e_kind,
    input  wire logic signed [COORD_BITS-1:0] e_x,
    input  wire logic signed [COORD_BITS-1:0] e_y,
    input  wire logic        [COORD_BITS-2:0] e_w,
    input  wire logic        [COORD_BITS-2:0] e_h,
    output logic                              blocked
);

    import amcc_pkg::*;

    logic signed [COORD_BITS:0] qx_ext;
    logic signed [COORD_BITS:0] qy_ext;
    logic signed [COORD_BITS:0] ex_ext;
    logic signed [COORD_BITS:0] ey_ext;
    logic signed [COORD_BITS:0] e_right;
    logic signed [COORD_BITS:0] e_bottom;
    logic                       overlap;
    logic                       relevant;

    assign qx_ext   = (COORD_BITS+1)'(q_x);
    assign qy_ext   = (COORD_BITS+1)'(q_y);
    assign ex_ext   = (COORD_BITS+1)'(e_x);
    assign ey_ext   = (COORD_BITS+1)'(e_y);
    assign e_right  = ex_ext + signed'((COORD_BITS+1)'(e_w));
    assign e_bottom = ey_ext + signed'((COORD_BITS+1)'(e_h));

    assign overlap = !((q_right <= ex_ext) || (qx_ext >= e_right) ||
                       (q_bottom <= ey_ext) || (qy_ext >= e_bottom));

    always_comb
    begin
        case (e_kind)
            KIND_OBSTACLE: relevant = 1'b1;
            KIND_ENEMY:    relevant = !(q_flags.has_self && (e_x == self_x) && (e_y == self_y));
            KIND_PLAYER:   relevant = !q_flags.is_player;
            default:       relevant = 1'b0;
        endcase
    end

    assign blocked = q_flags_valid && e_valid && relevant && overlap;

endmodule

`default_nettype wire

// ----- sim/aabb_move_clearance_check_core_tb.sv -----
// Self-checking testbench for aabb_move_clearance_check_core: directed and random table writes
// and rectangle queries, with window changes between phases. Depends on amcc_pkg and the RTL.
`timescale 1ns / 1ps

module aabb_move_clearance_check_core_tb;

    import amcc_pkg::*;

    localparam int  TABLE_SLOTS  = 32;
    localparam int  COORD_BITS   = 16;
    localparam int  LIMIT_CYCLES = 600000;
    localparam kind_t KIND_SPARE = 2'd3;

    typedef struct {
        logic                     op;
        logic [4:0]               index;
        logic                     entry_valid;
        kind_t                    kind;
        logic signed [15:0]       pos_x;
        logic signed [15:0]       pos_y;
        logic [14:0]              box_w;
        logic [14:0]              box_h;
        logic                     is_player;
        logic                     has_self;
        logic signed [15:0]       self_x;
        logic signed [15:0]       self_y;
    } move_item_t;

    typedef struct {
        logic allowed;
        logic out_of_bounds;
    } verdict_t;

    class clearance_scoreboard;
        logic [15:0] win_w;
        logic [15:0] win_h;
        bit          slot_valid [TABLE_SLOTS];
        kind_t       slot_kind [TABLE_SLOTS];
        int          slot_x [TABLE_SLOTS];
        int          slot_y [TABLE_SLOTS];
        int          slot_w [TABLE_SLOTS];
        int          slot_h [TABLE_SLOTS];
        verdict_t    pending [$];
        int          errors;

        function new();
            win_w = 16'hFFFF;
            win_h = 16'hFFFF;
            errors = 0;
            foreach (slot_valid[i])
            begin
                slot_valid[i] = 1'b0;
                slot_kind[i] = KIND_OBSTACLE;
                slot_x[i] = 0;
                slot_y[i] = 0;
                slot_w[i] = 0;
                slot_h[i] = 0;
            end
        endfunction

        function void set_window(logic [CFG_INDEX_BITS-1:0] idx, logic [15:0] value);
            if (idx == CFG_WINDOW_WIDTH)
                win_w = value;
            else if (idx == CFG_WINDOW_HEIGHT)
                win_h = value;
        endfunction

        function void note_item(move_item_t it);
            int       qx;
            int       qy;
            int       qw;
            int       qh;
            int       sx;
            int       sy;
            bit       skip;
            verdict_t v;
            qx = it.pos_x;
            qy = it.pos_y;
            qw = it.box_w;
            qh = it.box_h;
            sx = it.self_x;
            sy = it.self_y;
            if (it.op == OP_WRITE)
            begin
                if (it.index < TABLE_SLOTS)
                begin
                    slot_valid[it.index] = it.entry_valid;
                    slot_kind[it.index] = it.kind;
                    slot_x[it.index] = qx;
                    slot_y[it.index] = qy;
                    slot_w[it.index] = qw;
                    slot_h[it.index] = qh;
                end
                return;
            end
            v.out_of_bounds = (qx < 0) || (qy < 0) || (qx + qw > int'(win_w)) ||
                              (qy + qh > int'(win_h));
            v.allowed = !v.out_of_bounds;
            for (int i = 0; i < TABLE_SLOTS && v.allowed; i++)
            begin
                skip = !slot_valid[i] || slot_kind[i] == KIND_SPARE ||
                       (slot_kind[i] == KIND_PLAYER && it.is_player) ||
                       (slot_kind[i] == KIND_ENEMY && it.has_self &&
                        slot_x[i] == sx && slot_y[i] == sy);
                if (!skip && !(qx + qw <= slot_x[i] || qx >= slot_x[i] + slot_w[i] ||
                               qy + qh <= slot_y[i] || qy >= slot_y[i] + slot_h[i]))
                    v.allowed = 1'b0;
            end
            pending.push_back(v);
        endfunction

        function void check_result(logic allowed, logic out_of_bounds);
            verdict_t v;
            if (pending.size() == 0)
            begin
                $error("result beat with no query outstanding");
                errors++;
                return;
            end
            v = pending.pop_front();
            if (allowed !== v.allowed)
            begin
                $error("allowed mismatch: expected %0b, got %0b", v.allowed, allowed);
                errors++;
            end
            if (out_of_bounds !== v.out_of_bounds)
            begin
                $error("out_of_bounds mismatch: expected %0b, got %0b",
                       v.out_of_bounds, out_of_bounds);
                errors++;
            end
        endfunction
    endclass

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         start = 1'b0;
    logic                         busy;
    logic                         op = OP_WRITE;
    logic [4:0]                   index = '0;
    logic                         entry_valid = 1'b0;
    kind_t                        entry_kind = KIND_OBSTACLE;
    logic signed [COORD_BITS-1:0] pos_x = '0;
    logic signed [COORD_BITS-1:0] pos_y = '0;
    logic [COORD_BITS-2:0]        box_width = '0;
    logic [COORD_BITS-2:0]        box_height = '0;
    logic                         is_player = 1'b0;
    logic                         has_self = 1'b0;
    logic signed [COORD_BITS-1:0] self_x = '0;
    logic signed [COORD_BITS-1:0] self_y = '0;
    logic                         done;
    logic                         allowed;
    logic                         out_of_bounds;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [CFG_INDEX_BITS-1:0]    cfg_index = '0;
    logic [WINDOW_BITS-1:0]       cfg_data = '0;

    clearance_scoreboard sb = new();
    int                  cycle_count = 0;
    int                  sender_idle_pct = 0;
    logic signed [15:0]  anchor_x [TABLE_SLOTS];
    logic signed [15:0]  anchor_y [TABLE_SLOTS];

    aabb_move_clearance_check_core #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .COORD_BITS  (COORD_BITS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .op            (op),
        .index         (index),
        .entry_valid   (entry_valid),
        .entry_kind    (entry_kind),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .box_width     (box_width),
        .box_height    (box_height),
        .is_player     (is_player),
        .has_self      (has_self),
        .self_x        (self_x),
        .self_y        (self_y),
        .done          (done),
        .allowed       (allowed),
        .out_of_bounds (out_of_bounds),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(allowed, out_of_bounds);
    end

    function automatic move_item_t write_item(logic [4:0] idx, logic v, kind_t k,
                                              int x, int y, int w, int h);
        move_item_t it;
        it = '{OP_WRITE, idx, v, k, 16'(x), 16'(y), 15'(w), 15'(h), 1'b0, 1'b0, 16'd0, 16'd0};
        return it;
    endfunction

    function automatic move_item_t query_item(int x, int y, int w, int h, logic pl,
                                              logic hs, int sx, int sy);
        move_item_t it;
        it = '{OP_QUERY, 5'd0, 1'b0, KIND_OBSTACLE, 16'(x), 16'(y), 15'(w), 15'(h),
               pl, hs, 16'(sx), 16'(sy)};
        return it;
    endfunction

    function automatic logic signed [15:0] rand_coord();
        int pick;
        pick = $urandom_range(99);
        if (pick < 85)
            return 16'($urandom_range(1100));
        else if (pick < 95)
            return 16'($urandom);
        else
            return ($urandom_range(1) != 0) ? 16'sh7FFF : 16'sh8000;
    endfunction

    function automatic logic [14:0] rand_size();
        int pick;
        pick = $urandom_range(99);
        if (pick < 85)
            return 15'($urandom_range(200));
        else if (pick < 95)
            return 15'($urandom);
        else
            return ($urandom_range(1) != 0) ? 15'h7FFF : 15'h0000;
    endfunction

    function automatic move_item_t random_item();
        move_item_t it;
        int         s;
        s = $urandom_range(TABLE_SLOTS - 1);
        it.op = ($urandom_range(99) < 35) ? OP_WRITE : OP_QUERY;
        it.index = 5'($urandom);
        it.entry_valid = ($urandom_range(99) < 85);
        it.kind = ($urandom_range(99) < 6) ? KIND_SPARE : kind_t'($urandom_range(2));
        if (it.op == OP_QUERY && $urandom_range(99) < 60)
        begin
            it.pos_x = anchor_x[s] + 16'($urandom_range(60)) - 16'sd30;
            it.pos_y = anchor_y[s] + 16'($urandom_range(60)) - 16'sd30;
        end
        else
        begin
            it.pos_x = rand_coord();
            it.pos_y = rand_coord();
        end
        it.box_w = rand_size();
        it.box_h = rand_size();
        it.is_player = 1'($urandom);
        it.has_self = 1'($urandom);
        if ($urandom_range(99) < 70)
        begin
            it.self_x = anchor_x[s];
            it.self_y = anchor_y[s];
        end
        else
        begin
            it.self_x = 16'($urandom);
            it.self_y = 16'($urandom);
        end
        if (it.op == OP_WRITE)
        begin
            anchor_x[it.index] = it.pos_x;
            anchor_y[it.index] = it.pos_y;
        end
        return it;
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat is taken, with
    // start still high so that the caller either presents the next item or lowers it.
    task automatic send_item(move_item_t it);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start = 1'b0;
            @(negedge clk);
        end
        start = 1'b1;
        op = it.op;
        index = it.index;
        entry_valid = it.entry_valid;
        entry_kind = it.kind;
        pos_x = it.pos_x;
        pos_y = it.pos_y;
        box_width = it.box_w;
        box_height = it.box_h;
        is_player = it.is_player;
        has_self = it.has_self;
        self_x = it.self_x;
        self_y = it.self_y;
        do
            @(posedge clk);
        while (busy);
        sb.note_item(it);
        @(negedge clk);
    endtask

    task automatic write_cfg(logic [CFG_INDEX_BITS-1:0] idx, logic [15:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_window(idx, value);
        @(negedge clk);
    endtask

    task automatic run_phase(int count, int idle_pct, logic [15:0] ww, logic [15:0] wh);
        int x0;
        int wv;
        start = 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (TABLE_SLOTS + 4) @(posedge clk);
        @(negedge clk);
        write_cfg(CFG_WINDOW_WIDTH, ww);
        write_cfg(CFG_WINDOW_HEIGHT, wh);
        cfg_valid = 1'b0;
        sender_idle_pct = idle_pct;
        // Probe right and bottom window edges and one unit beyond, where box sizes reach.
        x0 = (ww > 32767) ? 32767 : 0;
        wv = (ww - x0 > 32767) ? 32767 : ww - x0;
        send_item(query_item(x0, 0, wv, 0, 1'b0, 1'b0, 0, 0));
        send_item(query_item(x0, 0, (wv < 32767) ? wv + 1 : wv, 0, 1'b0, 1'b0, 0, 0));
        x0 = (wh > 32767) ? 32767 : 0;
        wv = (wh - x0 > 32767) ? 32767 : wh - x0;
        send_item(query_item(0, x0, 0, wv, 1'b1, 1'b0, 0, 0));
        send_item(query_item(0, x0, 0, (wv < 32767) ? wv + 1 : wv, 1'b1, 1'b0, 0, 0));
        repeat (count) send_item(random_item());
    endtask

    initial
    begin
        foreach (anchor_x[i])
        begin
            anchor_x[i] = 16'sd0;
            anchor_y[i] = 16'sd0;
        end
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        sender_idle_pct = 22;
        send_item(query_item(0, 0, 0, 0, 1'b0, 1'b0, 0, 0));
        send_item(query_item(-1, 10, 5, 5, 1'b0, 1'b0, 0, 0));
        send_item(query_item(10, -32768, 5, 5, 1'b0, 1'b0, 0, 0));
        send_item(query_item(32767, 32767, 32767, 32767, 1'b1, 1'b1, -32768, 32767));
        send_item(write_item(5'd0, 1'b1, KIND_OBSTACLE, 100, 100, 50, 50));
        send_item(query_item(150, 100, 10, 10, 1'b0, 1'b0, 0, 0));
        send_item(query_item(149, 149, 10, 10, 1'b0, 1'b0, 0, 0));
        send_item(query_item(110, 110, 0, 10, 1'b0, 1'b0, 0, 0));
        send_item(write_item(5'd31, 1'b1, KIND_PLAYER, 300, 300, 20, 20));
        send_item(query_item(305, 305, 5, 5, 1'b1, 1'b0, 0, 0));
        send_item(query_item(305, 305, 5, 5, 1'b0, 1'b0, 0, 0));
        send_item(write_item(5'd5, 1'b1, KIND_ENEMY, 500, 500, 30, 30));
        send_item(query_item(510, 510, 5, 5, 1'b0, 1'b1, 500, 500));
        send_item(query_item(510, 510, 5, 5, 1'b0, 1'b1, 500, 501));
        send_item(query_item(510, 510, 5, 5, 1'b1, 1'b0, 500, 500));
        send_item(write_item(5'd7, 1'b1, KIND_SPARE, 700, 700, 30, 30));
        send_item(query_item(710, 710, 5, 5, 1'b0, 1'b0, 0, 0));
        send_item(write_item(5'd8, 1'b0, KIND_OBSTACLE, 900, 900, 30, 30));
        send_item(query_item(910, 910, 5, 5, 1'b0, 1'b0, 0, 0));
        send_item(write_item(5'd9, 1'b1, KIND_OBSTACLE, 1000, 1000, 0, 0));
        send_item(query_item(990, 990, 20, 20, 1'b0, 1'b0, 0, 0));
        send_item(write_item(5'd30, 1'b1, KIND_OBSTACLE, -32768, -32768, 32767, 32767));
        send_item(write_item(5'd16, 1'b1, KIND_ENEMY, 32767, 32767, 32767, 32767));
        send_item(query_item(32767, 32767, 1, 1, 1'b1, 1'b0, 0, 0));

        run_phase(300, 22, 16'd1024, 16'd768);
        run_phase(280, 71, 16'd65535, 16'd1000);
        run_phase(30, 0, 16'd0, 16'd0);
        run_phase(220, 0, 16'($urandom_range(200, 1200)), 16'($urandom_range(200, 1200)));
        start = 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (TABLE_SLOTS + 8) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/amcc_pkg.sv
rtl/amcc_table.sv
rtl/amcc_overlap.sv
rtl/aabb_move_clearance_check_core.sv
sim/aabb_move_clearance_check_core_tb.sv
